### hdl/fir_pkg.sv
// Package for the 16-bit FIR filter.
// Holds the shared widths, request codes and the control and status structs
// between the sequencer and the multiply-accumulate datapath. No dependencies.
package fir_pkg;

  localparam int DATA_W       = 16;
  localparam int SHIFT_W      = 6;
  localparam int COEF_IDX_W   = 6;
  localparam int TAPS_DEFAULT = 64;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd16;

  // Request codes carried in req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // One tap issued to the datapath.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } fir_mac_ctl_t;

  // Datapath status: done holds once the last product has been summed.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } fir_mac_sts_t;

endpackage

### hdl/fir_in_if.sv
// Request channel of the FIR filter: sample items and coefficient writes.
// Depends on fir_pkg.
interface fir_in_if import fir_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [DATA_W-1:0]     sample_in;
  logic        [COEF_IDX_W-1:0] coef_index;
  logic signed [DATA_W-1:0]     coef_value;

  modport source (output valid, req_type, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, req_type, sample_in, coef_index, coef_value, output ready);
endinterface

### hdl/fir_out_if.sv
// Result channel of the FIR filter: one filtered sample per sample item.
// Depends on fir_pkg.
interface fir_out_if import fir_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

### hdl/fir_cfg_if.sv
// Configuration write channel of the FIR filter (result shift register).
// Depends on fir_pkg.
interface fir_cfg_if import fir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SHIFT_W-1:0] result_shift;

  modport source (output valid, result_shift, input ready);
  modport sink   (input valid, result_shift, output ready);
endinterface

### hdl/fir_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fir_mac.sv
// Shared multiply-accumulate datapath of the FIR filter: a registered
// multiplier, a wide accumulator and the output shift. Depends on fir_pkg.
module fir_mac import fir_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fir_mac_ctl_t             ctl_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic signed [DATA_W-1:0] coef_i,
  input  logic [SHIFT_W-1:0]       shift_i,
  output fir_mac_sts_t             sts_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

  fir_mac_ctl_t             rd_ctl_q;
  fir_mac_ctl_t             prod_ctl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_shr;
  logic                     done_q;

  // The RAM read data lines up with the tap control in the cycle after issue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q   <= '0;
      prod_ctl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      rd_ctl_q   <= ctl_i;
      prod_ctl_q <= rd_ctl_q;
      priority if (ctl_i.vld) begin
        done_q <= 1'b0;
      end else if (prod_ctl_q.vld && prod_ctl_q.last) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coef_i;
    if (prod_ctl_q.vld) begin
      acc_q <= prod_ctl_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_shr  = acc_q >>> shift_i;

  assign sts_o.done   = done_q;
  assign sts_o.result = acc_shr[DATA_W-1:0];

endmodule

### hdl/fir_ctrl.sv
// Sequencer of the FIR filter: clearing pass after reset, request intake,
// tap issue over the delay line and coefficient RAMs, and the result register.
// Depends on fir_pkg and the channel interfaces.
module fir_ctrl import fir_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT,
  localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fir_in_if.sink            req_i,
  fir_out_if.source         res_o,
  output logic              delay_we_o,
  output logic [AW-1:0]     delay_waddr_o,
  output logic [DATA_W-1:0] delay_wdata_o,
  output logic [AW-1:0]     delay_raddr_o,
  output logic              coef_we_o,
  output logic [AW-1:0]     coef_waddr_o,
  output logic [DATA_W-1:0] coef_wdata_o,
  output logic [AW-1:0]     coef_raddr_o,
  output fir_mac_ctl_t      mac_ctl_o,
  input  fir_mac_sts_t      mac_sts_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] filtered_q, filtered_d;
  logic              accept;
  logic              coef_in_range;
  logic [AW-1:0]     slot_next;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign coef_in_range = (32'(req_i.coef_index) < 32'(TAPS));
  assign slot_next     = (slot_q == LAST) ? '0 : slot_q + 1'b1;

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    out_vld_d     = out_vld_q;
    filtered_d    = filtered_q;
    delay_we_o    = 1'b0;
    delay_waddr_o = slot_q;
    delay_wdata_o = req_i.sample_in;
    coef_we_o     = 1'b0;
    coef_waddr_o  = AW'(req_i.coef_index);
    coef_wdata_o  = req_i.coef_value;
    mac_ctl_o     = '0;

    if (res_o.valid && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        delay_we_o    = 1'b1;
        delay_waddr_o = cnt_q;
        delay_wdata_o = '0;
        coef_we_o     = 1'b1;
        coef_waddr_o  = cnt_q;
        coef_wdata_o  = '0;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_SAMPLE) begin
            // The slot after the new sample holds the oldest one.
            delay_we_o = 1'b1;
            slot_d     = slot_next;
            pos_d      = slot_next;
            cnt_d      = '0;
            state_d    = ST_RUN;
          end else begin
            coef_we_o = coef_in_range;
          end
        end
      end
      ST_RUN: begin
        mac_ctl_o.vld   = 1'b1;
        mac_ctl_o.first = (cnt_q == '0);
        mac_ctl_o.last  = (cnt_q == LAST);
        pos_d           = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_WAIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (mac_sts_i.done && (!out_vld_q || res_o.ready)) begin
          out_vld_d  = 1'b1;
          filtered_d = mac_sts_i.result;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign delay_raddr_o = pos_q;
  assign coef_raddr_o  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      slot_q    <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    filtered_q <= filtered_d;
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.filtered = filtered_q;

endmodule

### hdl/fir_filter_int16.sv
// Signed 16-bit FIR filter, one multiply-accumulate per tap through a shared multiplier.
// A sample item's result goes to the output register after its tap pass; the next item
// is taken once the result sits in the output register, so one item is handled at a time.
// A coefficient write gives no result.
// After reset a clearing pass zeroes both RAMs; requests wait for it,
// configuration writes are taken at any time. The result shift resets to 16.
module fir_filter_int16 import fir_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT,
  localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fir_in_if.sink    req_i,
  fir_cfg_if.sink   cfg_i,
  fir_out_if.source res_o
);

  logic [SHIFT_W-1:0] shift_q;
  logic               delay_we;
  logic [AW-1:0]      delay_waddr;
  logic [DATA_W-1:0]  delay_wdata;
  logic [AW-1:0]      delay_raddr;
  logic [DATA_W-1:0]  delay_rdata;
  logic               coef_we;
  logic [AW-1:0]      coef_waddr;
  logic [DATA_W-1:0]  coef_wdata;
  logic [AW-1:0]      coef_raddr;
  logic [DATA_W-1:0]  coef_rdata;
  fir_mac_ctl_t       mac_ctl;
  fir_mac_sts_t       mac_sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      shift_q <= cfg_i.result_shift;
    end
  end

  fir_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .res_o         (res_o),
    .delay_we_o    (delay_we),
    .delay_waddr_o (delay_waddr),
    .delay_wdata_o (delay_wdata),
    .delay_raddr_o (delay_raddr),
    .coef_we_o     (coef_we),
    .coef_waddr_o  (coef_waddr),
    .coef_wdata_o  (coef_wdata),
    .coef_raddr_o  (coef_raddr),
    .mac_ctl_o     (mac_ctl),
    .mac_sts_i     (mac_sts)
  );

  fir_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (delay_we),
    .waddr_i (delay_waddr),
    .wdata_i (delay_wdata),
    .raddr_i (delay_raddr),
    .rdata_o (delay_rdata)
  );

  fir_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  fir_mac #(.TAPS(TAPS)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (delay_rdata),
    .coef_i   (coef_rdata),
    .shift_i  (shift_q),
    .sts_o    (mac_sts)
  );

  // No request is taken while taps are being issued.
  a_no_req_during_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.vld |-> !req_i.ready)
    else $error("request channel ready while taps are issued");

  // The last tap ends the issue pass.
  a_last_ends_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.vld && mac_ctl.last |=> !mac_ctl.vld)
    else $error("tap issue continued past the last tap");

  // A stale done flag is gone once a new pass has started.
  a_done_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.vld && !mac_ctl.first |-> !mac_sts.done)
    else $error("accumulator reports done in the middle of a pass");

endmodule
